[hw/rtl/hmdu_pkg.sv]
// Shared types and constants for the HI/LO multiply/divide unit.
// No dependencies; every other file takes names from here by scope.
package hmdu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = $clog2(WordW);
  localparam logic [WordW-1:0] MinNeg  = 32'h8000_0000;
  localparam logic [WordW-1:0] AllOnes = 32'hffff_ffff;

  typedef enum logic [2:0] {
    OP_MULT  = 3'd0,
    OP_UMUL  = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MTHI  = 3'd4,
    OP_MTLO  = 3'd5,
    OP_MFHI  = 3'd6,
    OP_MFLO  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_cmd_t;

  typedef struct packed {
    logic done;
  } iter_sts_t;

endpackage

[hw/rtl/hmdu_ifs.sv]
// Request and response channel interfaces for the multiply/divide unit.
// Depends on hmdu_pkg for the word width.
interface hmdu_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic [hmdu_pkg::WordW-1:0]    a_value;
  logic [hmdu_pkg::WordW-1:0]    b_value;

  modport source (output valid, op, a_value, b_value, input ready);
  modport sink   (input valid, op, a_value, b_value, output ready);
endinterface

interface hmdu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hmdu_pkg::WordW-1:0]    read_value;
  logic                          divide_skipped;

  modport source (output valid, read_value, divide_skipped, input ready);
  modport sink   (input valid, read_value, divide_skipped, output ready);
endinterface

[hw/rtl/hmdu_iter.sv]
// Radix-2 iterative unsigned multiply (shift-add) and divide (restoring).
// One operand bit per cycle; depends on hmdu_pkg.
module hmdu_iter (
  input  logic                       clk,
  input  logic                       rst,
  input  hmdu_pkg::iter_cmd_t        cmd,
  input  logic [hmdu_pkg::WordW-1:0] op_a,
  input  logic [hmdu_pkg::WordW-1:0] op_b,
  output hmdu_pkg::iter_sts_t        sts,
  output logic [hmdu_pkg::WordW-1:0] hi_res,
  output logic [hmdu_pkg::WordW-1:0] lo_res
);

  localparam int unsigned W = hmdu_pkg::WordW;

  logic [W-1:0]                 hi_acc;
  logic [W-1:0]                 lo_acc;
  logic [W-1:0]                 opnd;
  logic                         is_div;
  logic                         busy;
  logic                         done;
  logic [hmdu_pkg::CntW-1:0]    cnt;

  logic [W:0]   mul_sum;
  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic [W-1:0] hi_acc_next;
  logic [W-1:0] lo_acc_next;

  always_comb begin
    mul_sum = {1'b0, hi_acc} + (lo_acc[0] ? {1'b0, opnd} : '0);
    shifted = {hi_acc, lo_acc[W-1]};
    diff    = {1'b0, shifted} - {2'b00, opnd};
    if (is_div) begin
      hi_acc_next = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      lo_acc_next = {lo_acc[W-2:0], ~diff[W+1]};
    end else begin
      hi_acc_next = mul_sum[W:1];
      lo_acc_next = {mul_sum[0], lo_acc[W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= hmdu_pkg::CntW'(W - 1);
      end else if (busy) begin
        cnt  <= cnt - 1'b1;
        busy <= (cnt != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_div <= cmd.is_div;
      opnd   <= cmd.is_div ? op_b : op_a;
      hi_acc <= '0;
      lo_acc <= cmd.is_div ? op_a : op_b;
    end else if (busy) begin
      hi_acc <= hi_acc_next;
      lo_acc <= lo_acc_next;
    end
  end

  assign sts.done = done;
  assign hi_res   = hi_acc;
  assign lo_res   = lo_acc;

endmodule

[hw/rtl/hilo_multiply_divide_unit.sv]
// MIPS-style multiply/divide unit holding HI and LO, one word in, one word out per item.
// Multiply and divide run the bit-serial shift-add/restoring loop in hmdu_iter, then
// apply signs and write HI/LO, then load the result register. Move-to, move-from and
// skipped divides bypass the loop and go straight to the result register. One item is
// in flight at a time and the next word is accepted the cycle after the result loads; the
// result register lets that word be accepted while a result waits. Depends on hmdu_pkg,
// hmdu_ifs and hmdu_iter.
module hilo_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst,
  hmdu_req_if.sink    req,
  hmdu_rsp_if.source  rsp
);

  localparam int unsigned W = hmdu_pkg::WordW;

  hmdu_pkg::state_t    state;
  hmdu_pkg::state_t    state_next;
  hmdu_pkg::op_t       req_op;
  hmdu_pkg::iter_cmd_t cmd;
  hmdu_pkg::iter_sts_t sts;

  logic [W-1:0] hi_word;
  logic [W-1:0] lo_word;
  logic [W-1:0] pend_value;
  logic         pend_skip;
  logic         neg_lo;
  logic         neg_hi;
  logic         is_div;
  logic [W-1:0] rsp_value;
  logic         rsp_skip;
  logic         rsp_valid;

  logic         accept;
  logic         load_rsp;
  logic         is_signed;
  logic         is_arith;
  logic         is_divide;
  logic         skip;
  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;
  logic [W-1:0] hi_res;
  logic [W-1:0] lo_res;
  logic [2*W-1:0] prod;

  assign req_op    = hmdu_pkg::op_t'(req.op);
  assign accept    = req.valid && req.ready;
  assign is_signed = (req_op == hmdu_pkg::OP_MULT) || (req_op == hmdu_pkg::OP_DIV);
  assign is_divide = (req_op == hmdu_pkg::OP_DIV) || (req_op == hmdu_pkg::OP_DIVU);
  assign is_arith  = is_divide || (req_op == hmdu_pkg::OP_MULT) ||
                     (req_op == hmdu_pkg::OP_UMUL);
  assign skip      = is_divide && ((req.b_value == '0) ||
                     ((req_op == hmdu_pkg::OP_DIV) && (req.a_value == hmdu_pkg::MinNeg) &&
                      (req.b_value == hmdu_pkg::AllOnes)));
  assign a_mag     = (is_signed && req.a_value[W-1]) ? (~req.a_value + 1'b1) : req.a_value;
  assign b_mag     = (is_signed && req.b_value[W-1]) ? (~req.b_value + 1'b1) : req.b_value;
  assign prod      = {hi_res, lo_res};

  hmdu_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .op_a   (a_mag),
    .op_b   (b_mag),
    .sts    (sts),
    .hi_res (hi_res),
    .lo_res (lo_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      hmdu_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (is_arith && !skip) ? hmdu_pkg::ST_BUSY : hmdu_pkg::ST_DONE;
        end
      end
      hmdu_pkg::ST_BUSY: begin
        if (sts.done) begin
          state_next = hmdu_pkg::ST_DONE;
        end
      end
      hmdu_pkg::ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = hmdu_pkg::ST_IDLE;
        end
      end
      default: state_next = hmdu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    cmd.start  = 1'b0;
    cmd.is_div = is_divide;
    load_rsp   = 1'b0;
    case (state)
      hmdu_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        cmd.start = req.valid && is_arith && !skip;
      end
      hmdu_pkg::ST_DONE: begin
        load_rsp = !rsp_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hmdu_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
      hi_word   <= '0;
      lo_word   <= '0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept && (req_op == hmdu_pkg::OP_MTHI)) begin
        hi_word <= req.a_value;
      end
      if (accept && (req_op == hmdu_pkg::OP_MTLO)) begin
        lo_word <= req.a_value;
      end
      if ((state == hmdu_pkg::ST_BUSY) && sts.done) begin
        if (is_div) begin
          lo_word <= neg_lo ? (~lo_res + 1'b1) : lo_res;
          hi_word <= neg_hi ? (~hi_res + 1'b1) : hi_res;
        end else begin
          {hi_word, lo_word} <= neg_lo ? (~prod + 1'b1) : prod;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_div     <= is_divide;
      neg_lo     <= is_signed && (req.a_value[W-1] ^ req.b_value[W-1]);
      neg_hi     <= is_signed && req.a_value[W-1];
      pend_skip  <= skip;
      pend_value <= (req_op == hmdu_pkg::OP_MFHI) ? hi_word :
                    (req_op == hmdu_pkg::OP_MFLO) ? lo_word : '0;
    end
    if (load_rsp) begin
      rsp_value <= pend_value;
      rsp_skip  <= pend_skip;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.read_value     = rsp_value;
  assign rsp.divide_skipped = rsp_skip;

endmodule

[hw/rtl/hmdu_checker.sv]
// Port-level checks for hilo_multiply_divide_unit, attached by bind.
// Depends on hmdu_pkg and the top level's channel ports.
module hmdu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [hmdu_pkg::WordW-1:0] read_value,
  input logic                       divide_skipped
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(divide_skipped))
    else $error("response word changed while stalled");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_skipped |-> read_value == '0)
    else $error("skipped divide returned a nonzero read value");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("request taken while an item is in flight");

  a_ready_with_rsp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> req_ready)
    else $error("unit not ready when a new response appears");

endmodule

bind hilo_multiply_divide_unit hmdu_checker u_hmdu_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .read_value     (rsp.read_value),
  .divide_skipped (rsp.divide_skipped)
);

[tb/tb.sv]
// Self-checking bench for hilo_multiply_divide_unit: directed and random words, predicted HI/LO.
// Needs hmdu_pkg, hmdu_ifs and the unit's RTL; a scoreboard class tracks HI/LO and read words.
module tb;

  class hilo_scoreboard;
    typedef struct {
      hmdu_pkg::op_t                 op;
      logic [hmdu_pkg::WordW-1:0]    read_value;
      logic                          divide_skipped;
    } read_word_t;

    logic [hmdu_pkg::WordW-1:0] hi_word;
    logic [hmdu_pkg::WordW-1:0] lo_word;
    read_word_t                 pending_reads[$];
    int                         mismatches;

    function new();
      hi_word = '0;
      lo_word = '0;
      mismatches = 0;
    endfunction

    function void accept_word(hmdu_pkg::op_t op, logic [hmdu_pkg::WordW-1:0] a,
                              logic [hmdu_pkg::WordW-1:0] b);
      read_word_t                 w;
      logic signed [63:0]         sprod;
      logic [63:0]                uprod;
      logic [hmdu_pkg::WordW-1:0] ma, mb, q, r;
      w.op = op;
      w.read_value = '0;
      w.divide_skipped = 1'b0;
      case (op)
        hmdu_pkg::OP_MULT: begin
          sprod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          hi_word = sprod[63:32];
          lo_word = sprod[31:0];
        end
        hmdu_pkg::OP_UMUL: begin
          uprod = {32'd0, a} * {32'd0, b};
          hi_word = uprod[63:32];
          lo_word = uprod[31:0];
        end
        hmdu_pkg::OP_DIV: begin
          if (b == '0 || (a == hmdu_pkg::MinNeg && b == hmdu_pkg::AllOnes)) begin
            w.divide_skipped = 1'b1;
          end else begin
            ma = a[31] ? (32'd0 - a) : a;
            mb = b[31] ? (32'd0 - b) : b;
            q = ma / mb;
            r = ma % mb;
            if (a[31] ^ b[31]) q = 32'd0 - q;
            if (a[31]) r = 32'd0 - r;
            lo_word = q;
            hi_word = r;
          end
        end
        hmdu_pkg::OP_DIVU: begin
          if (b == '0) begin
            w.divide_skipped = 1'b1;
          end else begin
            lo_word = a / b;
            hi_word = a % b;
          end
        end
        hmdu_pkg::OP_MTHI: hi_word = a;
        hmdu_pkg::OP_MTLO: lo_word = a;
        hmdu_pkg::OP_MFHI: w.read_value = hi_word;
        default: w.read_value = lo_word;
      endcase
      pending_reads.push_back(w);
    endfunction

    function void check_word(logic [hmdu_pkg::WordW-1:0] read_value, logic divide_skipped);
      read_word_t w;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: read_value=%h divide_skipped=%b",
                   read_value, divide_skipped);
        return;
      end
      w = pending_reads.pop_front();
      if (read_value !== w.read_value || divide_skipped !== w.divide_skipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: read_value exp %h got %h, divide_skipped exp %b got %b",
                   w.op.name(), w.read_value, read_value, w.divide_skipped, divide_skipped);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  hmdu_req_if req_if();
  hmdu_rsp_if rsp_if();

  hilo_scoreboard sb;
  int results_seen;
  int burst_left;

  hilo_multiply_divide_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      sb.check_word(rsp_if.read_value, rsp_if.divide_skipped);
      results_seen++;
    end
  end

  // receiver: stall pattern redrawn from four modes, one long hold-off mid-run
  initial begin
    int   cyc;
    int   mode;
    int   hold_left;
    bit   held;
    logic [7:0] mask;
    logic nxt;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    mask = 8'hff;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
        mask = 8'($urandom);
      end
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        hold_left = 500;
      end
      case (mode)
        0: nxt = 1'b1;
        1: nxt = 1'($urandom_range(0, 1));
        2: nxt = mask[cyc % 8];
        default: nxt = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        nxt = 1'b0;
        hold_left--;
      end
      rsp_if.ready <= nxt;
      cyc++;
    end
  end

  task automatic send_word(hmdu_pkg::op_t op, logic [hmdu_pkg::WordW-1:0] a,
                           logic [hmdu_pkg::WordW-1:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      burst_left = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.a_value <= a;
    req_if.b_value <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.accept_word(op, a, b);
    burst_left--;
  endtask

  function automatic logic [hmdu_pkg::WordW-1:0] pick_operand();
    logic [hmdu_pkg::WordW-1:0] specials[7];
    logic [hmdu_pkg::WordW-1:0] v;
    specials = '{32'h0, 32'h1, hmdu_pkg::AllOnes, hmdu_pkg::MinNeg, 32'h7fff_ffff,
                 32'h0000_ffff, 32'hffff_0000};
    case ($urandom_range(0, 9))
      0, 1, 2: v = specials[$urandom_range(0, 6)];
      3, 4: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic run_random(int count);
    int                         sent;
    int                         reads;
    hmdu_pkg::op_t              op;
    logic [hmdu_pkg::WordW-1:0] a, b;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_word($urandom_range(0, 1) ? hmdu_pkg::OP_MTHI : hmdu_pkg::OP_MTLO,
                    $urandom, $urandom);
          sent++;
        end
        op = hmdu_pkg::op_t'($urandom_range(0, 3));
        a = pick_operand();
        b = pick_operand();
        if (op == hmdu_pkg::OP_DIV && $urandom_range(0, 29) == 0) begin
          a = hmdu_pkg::MinNeg;
          b = hmdu_pkg::AllOnes;
        end
        send_word(op, a, b);
        sent++;
        reads = $urandom_range(1, 2);
        repeat (reads) begin
          send_word($urandom_range(0, 1) ? hmdu_pkg::OP_MFHI : hmdu_pkg::OP_MFLO,
                    $urandom, $urandom);
          sent++;
        end
      end else begin
        send_word(hmdu_pkg::op_t'($urandom_range(0, 7)), $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    results_seen = 0;
    burst_left = 0;
    rst = 1'b1;
    req_if.valid   <= 1'b0;
    req_if.op      <= hmdu_pkg::OP_MULT;
    req_if.a_value <= '0;
    req_if.b_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MTHI, hmdu_pkg::AllOnes, 32'h0);
    send_word(hmdu_pkg::OP_MTLO, 32'h0, hmdu_pkg::AllOnes);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MULT, hmdu_pkg::MinNeg, hmdu_pkg::MinNeg);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MULT, 32'h7fff_ffff, hmdu_pkg::MinNeg);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_UMUL, hmdu_pkg::AllOnes, hmdu_pkg::AllOnes);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_DIV, hmdu_pkg::MinNeg, hmdu_pkg::AllOnes);
    send_word(hmdu_pkg::OP_DIV, 32'h1234_5678, 32'h0);
    send_word(hmdu_pkg::OP_DIVU, hmdu_pkg::AllOnes, 32'h0);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_DIV, 32'hffff_fff9, 32'h2);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_DIVU, hmdu_pkg::AllOnes, 32'h0001_0000);
    send_word(hmdu_pkg::OP_MFHI, 32'h0, 32'h0);
    send_word(hmdu_pkg::OP_MFLO, 32'h0, 32'h0);

    run_random(700);

    req_if.valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_reads.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
